// ----- rtl/vmrut_pkg.sv -----
package vmrut_pkg;

    typedef struct packed {
        logic [31:0]        uniform_u;
        logic signed [31:0] uniform_v;
    } trial_t;

    typedef struct packed {
        logic               accepted;
        logic signed [31:0] angle;
    } result_t;

    typedef struct packed {
        logic signed [30:0] location;
        logic [31:0]        concentration;
        logic [31:0]        scale;
    } cfg_t;

    typedef enum logic [1:0] {
        REG_LOCATION      = 2'd0,
        REG_CONCENTRATION = 2'd1,
        REG_SCALE         = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [32:0] u1;
        logic        vneg;
        logic [31:0] vmag;
        logic [31:0] k;
    } job_t;

    typedef struct packed {
        logic [32:0] u1;
        logic        vneg;
        logic [31:0] k;
        logic [64:0] prod;
        logic        ovf;
        logic [30:0] q;
        logic [31:0] t2;
        logic        first;
        logic [31:0] m31;
        logic [4:0]  lz;
        logic        top;
        logic [5:0]  e;
        logic [32:0] zden;
        logic [30:0] z;
        logic [28:0] z2;
        logic [32:0] p;
        logic [32:0] lnm;
        logic [36:0] total;
        logic [36:0] nlog;
        logic [33:0] cx;
        logic [30:0] cq;
        logic [30:0] h;
        logic [31:0] g;
    } work_t;

    localparam int QUEUE_DEPTH  = 4;
    localparam int Q_BITS       = 31;
    localparam int Z_BITS       = 31;
    localparam int NORM_STEPS   = 5;
    localparam int HORNER_STEPS = 11;
    localparam int COS_STEPS    = 10;

    localparam logic [29:0] PI_Q28       = 30'd843314857;
    localparam logic [31:0] LN2_Q32      = 32'd2977044472;
    localparam logic [31:0] K_ONE        = 32'd16777216;
    localparam logic [31:0] SCALE_RST    = 32'd1240952792;
    localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
    localparam logic [32:0] P_INIT       = 33'd186737708;

    localparam logic [32:0] HORNER_C [HORNER_STEPS] = '{
        33'd204522252, 33'd226050910, 33'd252645135, 33'd286331153,
        33'd330382099, 33'd390451572, 33'd477218588, 33'd613566756,
        33'd858993459, 33'd1431655765, 33'h1_0000_0000
    };

    localparam logic [30:0] COS_RECIP [COS_STEPS] = '{
        31'd37185864, 31'd45210182, 31'd56143363, 31'd71582788, 31'd94394885,
        31'd130150524, 31'd190887435, 31'd306783378, 31'd572662306,
        31'd1431655765
    };

    localparam logic [8:0] COS_DIV [COS_STEPS] = '{
        9'd462, 9'd380, 9'd306, 9'd240, 9'd182, 9'd132, 9'd90, 9'd56, 9'd30, 9'd12
    };

endpackage

// ----- rtl/vmrut_front.sv -----
module vmrut_front
    import vmrut_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  trial_t trial,
    input  logic   trial_valid,
    output logic   trial_stall,
    output job_t   job,
    output logic   job_valid,
    input  logic   full
);

    logic front_vld_reg;
    logic front_vld_next;
    job_t job_reg;
    job_t job_next;
    logic take;
    logic [31:0] vraw;

    assign trial_stall = front_vld_reg && full;
    assign take        = trial_valid && !trial_stall;
    assign job         = job_reg;
    assign job_valid   = front_vld_reg;

    always_comb
    begin
        vraw          = trial.uniform_v;
        job_next.u1   = 33'(trial.uniform_u) + 33'd1;
        job_next.vneg = vraw[31];
        job_next.vmag = vraw[31] ? (~vraw + 32'd1) : vraw;
        job_next.k    = (cfg.concentration == 32'd0) ? K_ONE : cfg.concentration;
    end

    always_comb
    begin
        if (take)
        begin
            front_vld_next = 1'b1;
        end
        else if (front_vld_reg && !full)
        begin
            front_vld_next = 1'b0;
        end
        else
        begin
            front_vld_next = front_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_vld_reg <= 1'b0;
        end
        else
        begin
            front_vld_reg <= front_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg <= job_next;
        end
    end

endmodule

// ----- rtl/vmrut_queue.sv -----
module vmrut_queue
    import vmrut_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output job_t head,
    output logic empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    job_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;
    logic             push_ok;

    assign full    = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = push_valid && !full;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push_ok ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push_ok) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (push_ok && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance on push");

endmodule

// ----- rtl/vmrut_div.sv -----
module vmrut_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 34,
    parameter int QUO_W = 31,
    parameter int TAG_W = 8
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] tag,
    output logic [QUO_W-1:0] quo,
    output logic [TAG_W-1:0] tag_out
);

    localparam int W = DEN_W + QUO_W;

    logic [W-1:0]     rem_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];
    logic [TAG_W-1:0] tag_reg [QUO_W];
    logic [W-1:0]     rem_nx  [QUO_W];
    logic [DEN_W-1:0] den_nx  [QUO_W];
    logic [QUO_W-1:0] quo_nx  [QUO_W];
    logic [TAG_W-1:0] tag_nx  [QUO_W];

    always_comb
    begin
        logic [W-1:0]     rem_i;
        logic [QUO_W-1:0] quo_i;
        logic [W-1:0]     sub;
        for (int s = 0; s < QUO_W; s++)
        begin
            if (s == 0)
            begin
                rem_i     = W'(num);
                quo_i     = '0;
                den_nx[s] = den;
                tag_nx[s] = tag;
            end
            else
            begin
                rem_i     = rem_reg[s-1];
                quo_i     = quo_reg[s-1];
                den_nx[s] = den_reg[s-1];
                tag_nx[s] = tag_reg[s-1];
            end
            sub = W'(den_nx[s]) << (QUO_W - 1 - s);
            if (rem_i >= sub)
            begin
                rem_nx[s] = rem_i - sub;
                quo_nx[s] = quo_i | (QUO_W'(1) << (QUO_W - 1 - s));
            end
            else
            begin
                rem_nx[s] = rem_i;
                quo_nx[s] = quo_i;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < QUO_W; s++)
            begin
                rem_reg[s] <= rem_nx[s];
                den_reg[s] <= den_nx[s];
                quo_reg[s] <= quo_nx[s];
                tag_reg[s] <= tag_nx[s];
            end
        end
    end

    assign quo     = quo_reg[QUO_W-1];
    assign tag_out = tag_reg[QUO_W-1];

endmodule

// ----- rtl/vmrut_back.sv -----
module vmrut_back
    import vmrut_pkg::*;
#(
    parameter int ANGLE_WIDTH = 32
) (
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  job_t    job,
    input  logic    job_valid,
    output logic    pop,
    output result_t result,
    output logic    result_valid,
    input  logic    result_stall
);

    localparam int WB  = $bits(work_t);
    localparam int LAT = 2 + Q_BITS + 3 + NORM_STEPS + 1 + Z_BITS + 1 + HORNER_STEPS
                       + 2 + 3 * COS_STEPS + 3;

    logic [LAT-1:0] vld_reg;
    logic           en;

    work_t s1_reg, s1_next, s2_reg, s2_next;
    work_t s3_reg, s3_next, s4_reg, s4_next, s5_reg, s5_next;
    work_t nrm_reg [NORM_STEPS];
    work_t nrm_next [NORM_STEPS];
    work_t zp_reg, zp_next, z2_reg, z2_next;
    work_t hor_reg [HORNER_STEPS];
    work_t hor_next [HORNER_STEPS];
    work_t ln_reg, ln_next, lg_reg, lg_next;
    work_t ca_reg [COS_STEPS];
    work_t ca_next [COS_STEPS];
    work_t cb_reg [COS_STEPS];
    work_t cb_next [COS_STEPS];
    work_t cc_reg [COS_STEPS];
    work_t cc_next [COS_STEPS];
    work_t g_reg, g_next, kg_reg, kg_next;
    result_t result_reg, result_next;

    logic [Q_BITS-1:0] q_quo;
    logic [WB-1:0]     dq_tag;
    work_t             dq_w;
    logic [Z_BITS-1:0] z_quo;
    logic [WB-1:0]     dz_tag;
    work_t             dz_w;

    assign en           = !(vld_reg[LAT-1] && result_stall);
    assign pop          = en && job_valid;
    assign result_valid = vld_reg[LAT-1];
    assign result       = result_reg;

    always_comb
    begin
        logic [33:0] den;
        s1_next      = '0;
        s1_next.u1   = job.u1;
        s1_next.vneg = job.vneg;
        s1_next.k    = job.k;
        s1_next.prod = 65'(64'(cfg.scale) * 64'(job.vmag));

        s2_next      = s1_reg;
        den          = {s1_reg.u1, 1'b0};
        s2_next.ovf  = ({1'b0, s1_reg.prod[63:0]} >= {den, 31'd0});
        s2_next.prod = s2_next.ovf ? '0 : {1'b0, s1_reg.prod[63:0]};
    end

    vmrut_div #(.NUM_W(64), .DEN_W(34), .QUO_W(Q_BITS), .TAG_W(WB)) u_div_q (
        .clk     (clk),
        .en      (en),
        .num     (s2_reg.prod[63:0]),
        .den     ({s2_reg.u1, 1'b0}),
        .tag     (s2_reg),
        .quo     (q_quo),
        .tag_out (dq_tag)
    );

    assign dq_w = work_t'(dq_tag);

    always_comb
    begin
        logic [61:0] qq;
        logic [31:0] t2;
        s3_next      = dq_w;
        s3_next.q    = q_quo;
        s3_next.ovf  = dq_w.ovf || (q_quo > 31'(PI_Q28));
        qq           = 62'(q_quo) * 62'(q_quo);
        s3_next.prod = 65'(qq);

        s4_next      = s3_reg;
        t2           = s3_reg.prod[59:28];
        s4_next.t2   = t2;
        s4_next.prod = 65'(64'(s3_reg.k) * 64'(t2));

        s5_next       = s4_reg;
        s5_next.first = (s4_reg.prod[63:0] <
                         (64'(33'h1_0000_0000 - s4_reg.u1) << 22));
        s5_next.m31   = s4_reg.u1[31:0];
        s5_next.lz    = '0;
        s5_next.top   = s4_reg.u1[32];
    end

    always_comb
    begin
        work_t w;
        for (int i = 0; i < NORM_STEPS; i++)
        begin
            w = (i == 0) ? s5_reg : nrm_reg[i-1];
            if ((w.m31 >> (32 - (16 >> i))) == 32'd0)
            begin
                w.m31 = w.m31 << (16 >> i);
                w.lz  = w.lz + 5'(16 >> i);
            end
            nrm_next[i] = w;
        end
    end

    always_comb
    begin
        logic [31:0] m;
        logic [61:0] zz;
        zp_next      = nrm_reg[NORM_STEPS-1];
        m            = zp_next.top ? 32'h8000_0000 : zp_next.m31;
        zp_next.e    = zp_next.top ? 6'd32 : 6'd31 - {1'b0, zp_next.lz};
        zp_next.m31  = m;
        zp_next.prod = {2'b00, m[30:0], 32'd0};
        zp_next.zden = {1'b0, m} + 33'h0_8000_0000;

        z2_next      = dz_w;
        z2_next.z    = z_quo;
        zz           = 62'(z_quo) * 62'(z_quo);
        z2_next.z2   = zz[60:32];
        z2_next.p    = P_INIT;
    end

    vmrut_div #(.NUM_W(64), .DEN_W(33), .QUO_W(Z_BITS), .TAG_W(WB)) u_div_z (
        .clk     (clk),
        .en      (en),
        .num     (zp_reg.prod[63:0]),
        .den     (zp_reg.zden),
        .tag     (zp_reg),
        .quo     (z_quo),
        .tag_out (dz_tag)
    );

    assign dz_w = work_t'(dz_tag);

    always_comb
    begin
        work_t w;
        logic [61:0] mp;
        for (int i = 0; i < HORNER_STEPS; i++)
        begin
            w           = (i == 0) ? z2_reg : hor_reg[i-1];
            mp          = 62'(w.z2) * 62'(w.p);
            w.p         = 33'(mp[61:32]) + HORNER_C[i];
            hor_next[i] = w;
        end
    end

    always_comb
    begin
        logic [63:0] zp;
        logic [37:0] tot;
        ln_next       = hor_reg[HORNER_STEPS-1];
        zp            = 64'(ln_next.z) * 64'(ln_next.p);
        ln_next.lnm   = {zp[63:32], 1'b0};
        tot           = 38'(6'd32 - ln_next.e) * 38'(LN2_Q32);
        ln_next.total = tot[36:0];

        lg_next       = ln_reg;
        lg_next.nlog  = (ln_reg.total > 37'(ln_reg.lnm)) ?
                        ln_reg.total - 37'(ln_reg.lnm) : '0;
        lg_next.h     = ONE_Q30;
    end

    always_comb
    begin
        work_t w;
        logic [62:0] tp;
        logic [64:0] y;
        logic [39:0] prd;
        logic [33:0] r;
        logic [31:0] term;
        for (int i = 0; i < COS_STEPS; i++)
        begin
            w          = (i == 0) ? lg_reg : cc_reg[i-1];
            tp         = 63'(w.t2) * 63'(w.h);
            w.cx       = tp[61:28];
            ca_next[i] = w;

            w          = ca_reg[i];
            y          = 65'(w.cx) * 65'(COS_RECIP[i]);
            w.cq       = y[64:34];
            cb_next[i] = w;

            w          = cb_reg[i];
            prd        = 40'(w.cq) * 40'(COS_DIV[i]);
            r          = w.cx - prd[33:0];
            term       = 32'(w.cq) + ((r >= 34'(COS_DIV[i])) ? 32'd1 : 32'd0);
            w.h        = (term >= 32'(ONE_Q30)) ? '0 : 31'(32'(ONE_Q30) - term);
            cc_next[i] = w;
        end
    end

    always_comb
    begin
        logic [62:0] tp;
        logic [33:0] gp;
        logic        second;
        logic        acc;
        logic [63:0] mu64;
        logic [63:0] q64;
        logic [63:0] s64;
        logic [ANGLE_WIDTH-1:0] sw;
        logic [63:0] sx;
        g_next       = cc_reg[COS_STEPS-1];
        tp           = 63'(g_next.t2) * 63'(g_next.h);
        gp           = tp[62:29];
        g_next.g     = (gp > 34'h0_8000_0000) ? 32'h8000_0000 : gp[31:0];

        kg_next      = g_reg;
        kg_next.prod = 65'(64'(g_reg.k) * 64'(g_reg.g));

        second = (kg_reg.prod[63:0] <= (64'({kg_reg.nlog, 1'b0}) << 22));
        acc    = !kg_reg.ovf && (kg_reg.first || second);
        mu64   = {{33{cfg.location[30]}}, cfg.location};
        q64    = 64'(kg_reg.q);
        s64    = kg_reg.vneg ? mu64 - q64 : mu64 + q64;
        sw     = s64[ANGLE_WIDTH-1:0];
        sx     = {{(64-ANGLE_WIDTH){sw[ANGLE_WIDTH-1]}}, sw};
        result_next.accepted = acc;
        result_next.angle    = acc ? sx[31:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            for (int i = 0; i < NORM_STEPS; i++)
            begin
                nrm_reg[i] <= nrm_next[i];
            end
            zp_reg <= zp_next;
            z2_reg <= z2_next;
            for (int i = 0; i < HORNER_STEPS; i++)
            begin
                hor_reg[i] <= hor_next[i];
            end
            ln_reg <= ln_next;
            lg_reg <= lg_next;
            for (int i = 0; i < COS_STEPS; i++)
            begin
                ca_reg[i] <= ca_next[i];
                cb_reg[i] <= cb_next[i];
                cc_reg[i] <= cc_next[i];
            end
            g_reg      <= g_next;
            kg_reg     <= kg_next;
            result_reg <= result_next;
        end
    end

endmodule

// ----- rtl/von_mises_ratio_uniforms_test.sv -----
// channel   dir  payload          handshake
// trial     in   trial_t          trial_valid / trial_stall
// result    out  result_t         result_valid / result_stall
// cfg       in   cfg_index, data  cfg_write
//
// One trial per cycle sustained while no result is stalled; a request passes through
// the front register, the queue, and a 120-stage back pipeline set by two 31-step
// restoring dividers, the 11-step log series and the 10-step cosine series.
// Reset clears all valid state and loads the register defaults.
// A stalled result freezes the whole back pipeline; the queue of four and
// the front register keep taking requests until they fill.
module von_mises_ratio_uniforms_test
    import vmrut_pkg::*;
#(
    parameter int ANGLE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  trial_t      trial,
    input  logic        trial_valid,
    output logic        trial_stall,
    output result_t     result,
    output logic        result_valid,
    input  logic        result_stall
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    job_t front_job;
    logic front_valid;
    logic q_full;
    logic q_pop;
    job_t q_head;
    logic q_empty;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_LOCATION:      cfg_next.location      = cfg_data[30:0];
                REG_CONCENTRATION: cfg_next.concentration = cfg_data;
                REG_SCALE:         cfg_next.scale         = cfg_data;
                default:           cfg_next               = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.location      <= '0;
            cfg_reg.concentration <= K_ONE;
            cfg_reg.scale         <= SCALE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    vmrut_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .trial       (trial),
        .trial_valid (trial_valid),
        .trial_stall (trial_stall),
        .job         (front_job),
        .job_valid   (front_valid),
        .full        (q_full)
    );

    vmrut_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_data  (front_job),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    vmrut_back #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .job          (q_head),
        .job_valid    (!q_empty),
        .pop          (q_pop),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule

// ----- tb/von_mises_ratio_uniforms_test_checker.sv -----
module von_mises_ratio_uniforms_test_checker
    import vmrut_pkg::*;
#(
    parameter int ANGLE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  trial_t      trial,
    input  logic        trial_valid,
    input  logic        trial_stall,
    input  result_t     result,
    input  logic        result_valid,
    input  logic        result_stall,
    output int          errors,
    output int          outstanding,
    output int          accepts
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit [63:0] PI_LIMIT = 64'd843314857;
    localparam bit [63:0] LN2_FIX  = 64'd2977044472;
    localparam bit [63:0] ONE_30   = 64'd1 << 30;
    localparam bit [63:0] ONE_32   = 64'd1 << 32;

    bit [30:0] mu_reg;
    bit [31:0] kappa_reg;
    bit [31:0] scale_reg;
    result_t   pending_outcomes[$];

    assign outstanding = pending_outcomes.size();

    function automatic bit [63:0] cosine_gap(input bit [63:0] t2);
        bit [63:0] h;
        bit [63:0] d;
        bit [63:0] term;
        bit [63:0] g;
        h = ONE_30;
        for (int n = 11; n >= 2; n--)
        begin
            d = 64'(2 * n) * 64'(2 * n - 1);
            term = (t2 * h) / (d << 28);
            h = (term >= ONE_30) ? 64'd0 : ONE_30 - term;
        end
        g = (t2 * h) >> 29;
        return (g > (64'd2 << 30)) ? (64'd2 << 30) : g;
    endfunction

    function automatic bit [63:0] neg_ln_u(input bit [63:0] w);
        int        e;
        bit [63:0] m31;
        bit [63:0] z;
        bit [63:0] z2;
        bit [63:0] p;
        bit [63:0] lnm;
        bit [63:0] total;
        e = 0;
        while (e < 32 && (w >> (e + 1)) != 0)
            e++;
        m31 = (e <= 31) ? (w << (31 - e)) : (w >> 1);
        z = ((m31 - (64'd1 << 31)) << 32) / (m31 + (64'd1 << 31));
        z2 = (z * z) >> 32;
        p = ONE_32 / 23;
        for (int j = 10; j >= 0; j--)
            p = ONE_32 / 64'(2 * j + 1) + ((z2 * p) >> 32);
        lnm = 2 * ((z * p) >> 32);
        total = 64'(32 - e) * LN2_FIX;
        return (total > lnm) ? total - lnm : 64'd0;
    endfunction

    function automatic result_t predict_trial(input trial_t tr);
        result_t   r;
        bit [63:0] u1;
        bit        vneg;
        bit [63:0] vmag;
        bit [63:0] k;
        bit [63:0] q;
        bit [63:0] t2;
        bit [63:0] mu;
        bit [63:0] sum;
        bit [63:0] wmask;
        bit        first;
        bit        second;
        u1 = 64'(tr.uniform_u) + 1;
        vneg = tr.uniform_v[31];
        vmag = vneg ? (ONE_32 - 64'(unsigned'(tr.uniform_v))) : 64'(unsigned'(tr.uniform_v));
        k = (kappa_reg == 0) ? 64'(K_ONE) : 64'(kappa_reg);
        q = (64'(scale_reg) * vmag) / (u1 << 1);
        r = '0;
        if (q <= PI_LIMIT)
        begin
            t2 = (q * q) >> 28;
            first = (k * t2) < ((ONE_32 - u1) << 22);
            second = 0;
            if (!first)
                second = (k * cosine_gap(t2)) <= ((2 * neg_ln_u(u1)) << 22);
            r.accepted = first || second;
        end
        if (r.accepted)
        begin
            mu = {{33{mu_reg[30]}}, mu_reg};
            sum = vneg ? mu - q : mu + q;
            wmask = (64'd1 << ANGLE_WIDTH) - 1;
            sum &= wmask;
            if (sum[ANGLE_WIDTH-1])
                sum |= ~wmask;
            r.angle = sum[31:0];
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_reg    <= '0;
            kappa_reg <= K_ONE;
            scale_reg <= SCALE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LOCATION:      mu_reg    <= cfg_data[30:0];
                REG_CONCENTRATION: kappa_reg <= cfg_data;
                REG_SCALE:         scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    initial
    begin
        errors = 0;
        accepts = 0;
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && trial_valid && !trial_stall)
            pending_outcomes.push_back(predict_trial(trial));
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_outcomes.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: accepted=%0b angle=%0d",
                             result.accepted, result.angle);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (result.accepted)
                    accepts++;
                if (result.accepted !== want.accepted || result.angle !== want.angle)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: accepted exp %0b got %0b, angle exp %0d got %0d",
                                 want.accepted, result.accepted, want.angle, result.angle);
                end
            end
        end
    end
endmodule

// ----- tb/von_mises_ratio_uniforms_test_test.sv -----
module von_mises_ratio_uniforms_test_test;
    import vmrut_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int HOLD_CYCLES    = 400;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_write = 0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    trial_t      trial = '0;
    logic        trial_valid = 0;
    logic        trial_stall;
    result_t     result;
    logic        result_valid;
    logic        result_stall = 0;

    int errors;
    int outstanding;
    int accepts;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_trigger = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int trials_sent = 0;

    always #2 clk = ~clk;

    von_mises_ratio_uniforms_test u_top (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .trial(trial), .trial_valid(trial_valid),
        .trial_stall(trial_stall), .result(result), .result_valid(result_valid),
        .result_stall(result_stall)
    );

    von_mises_ratio_uniforms_test_checker u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .trial(trial), .trial_valid(trial_valid),
        .trial_stall(trial_stall), .result(result), .result_valid(result_valid),
        .result_stall(result_stall), .errors(errors), .outstanding(outstanding),
        .accepts(accepts)
    );

    always @(posedge clk)
    begin
        if (hold_trigger != hold_seen)
        begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1;
        end
        else
            result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((trial_valid && !trial_stall) || (result_valid && !result_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", idle_cycles);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_trial(input logic [31:0] u, input logic [31:0] v);
        logic stalled;
        while ($urandom_range(99) < send_idle_pct)
        begin
            trial_valid <= 0;
            @(posedge clk);
        end
        trial_valid <= 1;
        trial <= '{uniform_u: u, uniform_v: v};
        stalled = 1'b1;
        while (stalled)
        begin
            @(negedge clk);
            stalled = trial_stall;
            @(posedge clk);
        end
        trials_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 0;
    endtask

    task automatic drain;
        trial_valid <= 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_trial;
        logic [31:0] u;
        logic [31:0] v;
        int          pick;
        pick = $urandom_range(99);
        u = $urandom;
        v = $urandom;
        if (pick < 25)
            u = {2'b11, u[29:0]};
        else if (pick < 40)
            v = {{5{v[31]}}, v[26:0]};
        else if (pick < 48)
            u = u >> $urandom_range(31);
        send_trial(u, v);
    endtask

    initial
    begin
        logic [31:0] mus[5];
        logic [31:0] kappas[5];
        logic [31:0] scales[5];
        mus    = '{32'd0, 32'd843314857, -32'sd843314857, $urandom_range(843314857), 32'd0};
        kappas = '{32'd16777216, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd268435456};
        scales = '{32'd1240952792, 32'd3373259426, 32'd1, 32'd0, 32'd400000000};
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_trial(32'h0000_0000, 32'h0000_0000);
        send_trial(32'hFFFF_FFFF, 32'h0000_0000);
        send_trial(32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_trial(32'hFFFF_FFFF, 32'h8000_0000);
        send_trial(32'h0000_0000, 32'h8000_0000);
        send_trial(32'h0000_0000, 32'h7FFF_FFFF);
        send_trial(32'h0000_0000, 32'h0000_0001);
        send_trial(32'h8000_0000, 32'h4000_0000);
        send_trial(32'h8000_0000, 32'hC000_0000);
        send_trial(32'hF000_0000, 32'h1000_0000);
        send_trial(32'h0FFF_FFFF, 32'hF000_0000);
        send_trial(32'hC000_0000, 32'h6000_0000);
        send_trial(32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_trial(32'h0000_0001, 32'h0000_0002);
        drain();

        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(REG_LOCATION, mus[ph]);
            write_reg(REG_CONCENTRATION, kappas[ph]);
            write_reg(REG_SCALE, scales[ph]);
            send_trial(32'hFFFF_FFFF, 32'h7FFF_FFFF);
            send_trial(32'hFFFF_FFFF, 32'h8000_0000);
            for (int mode = 0; mode < 4; mode++)
            begin
                send_idle_pct  = (mode == 1) ? 74 : (mode == 3) ? 35 : 0;
                recv_stall_pct = (mode == 2) ? 74 : (mode == 3) ? 35 : 0;
                if (mode == 0 && ph == 1)
                    hold_trigger++;
                repeat (56) random_trial();
            end
            send_idle_pct = 0;
            recv_stall_pct = 0;
            drain();
        end

        $display("%0d trials over 5 register settings and 4 idle patterns, %0d accepted",
                 trials_sent, accepts);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
